/* hw/rtl/pott_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pott_pkg
// Types, codes and helpers shared by the periodic / one-shot timer table.
// ----------------------------------------------------------------------------
package pott_pkg;

    localparam int TIME_W      = 48;
    localparam int AMOUNT_W    = 32;
    localparam int TAG_W       = 16;
    localparam int MAX_RESULTS = 16;
    localparam int FIRE_W      = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_ADD_PER  = 2'd1,
        OP_ADD_ONE  = 2'd2,
        OP_CLEAR    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_ACK     = 2'd0,
        KIND_FIRED   = 2'd1,
        KIND_NOTHING = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_CB   = 2'd1,
        ST_ZERO_IV = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_TICK_RD,
        S_TICK_EVAL,
        S_TICK_END
    } state_t;

    typedef struct packed {
        logic                periodic;
        logic [TIME_W-1:0]   due;
        logic [AMOUNT_W-1:0] interval;
        logic [TAG_W-1:0]    tag;
    } slot_t;

    // Due time of now plus a delay, held at the top of the time range.
    function automatic logic [TIME_W-1:0] sat_add(
        input logic [TIME_W-1:0]   t,
        input logic [AMOUNT_W-1:0] d
    );
        logic [TIME_W:0] s;
        s = {1'b0, t} + {{(TIME_W + 1 - AMOUNT_W){1'b0}}, d};
        sat_add = s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

endpackage

/* hw/rtl/periodic_oneshot_timer_table_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_oneshot_timer_table_top
// Timer slot table in insertion order; adds, clears and ticks that fire,
// reschedule and compact slots through one compare/add unit.
// ----------------------------------------------------------------------------
// Add and clear are accepted while idle; the exec state then registers their word once the result port is free.
// A tick runs accept, setup, then for each slot a memory read state plus a
// compare / saturating add / write-back state on the shared unit, then a final
// pointer check and the last word.
// Throughput: one item at a time; input ready only while idle, and longer
// when the result port stalls.
// Reset: state, counts, pointers and valid flags clear at once; slot memory is not.
module periodic_oneshot_timer_table_top
    import pott_pkg::*;
#(
    parameter int JOB_SLOTS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [103:0]  s_tdata,   // now_ms[47:0], amount[79:48], job_tag[95:80],
                                     // has_callback[96], zero fill
    input  logic [1:0]    s_tuser,   // op[1:0]
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [23:0]   m_tdata,   // status[1:0], fired_tag[17:2], zero fill
    output logic [1:0]    m_tuser,   // kind[1:0]
    output logic          m_tlast
);

    localparam int AW    = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
    localparam int CNT_W = $clog2(JOB_SLOTS + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(JOB_SLOTS);
    localparam logic [FIRE_W-1:0] FIRE_MAX = FIRE_W'(MAX_RESULTS);

    // slot memory
    slot_t mem [JOB_SLOTS];
    slot_t rd_data_reg;
    logic  mem_we;
    logic [AW-1:0] mem_waddr;
    slot_t mem_wdata;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [AMOUNT_W-1:0] amount_reg, amount_next;
    logic [TAG_W-1:0]    tag_reg, tag_next;
    logic                cb_reg, cb_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [FIRE_W-1:0]   fire_cnt_reg, fire_cnt_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [TAG_W-1:0]    pend_tag_reg, pend_tag_next;
    logic                out_valid_reg, out_valid_next;
    kind_t               out_kind_reg, out_kind_next;
    status_t             out_status_reg, out_status_next;
    logic [TAG_W-1:0]    out_tag_reg, out_tag_next;
    logic                out_last_reg, out_last_next;

    logic      out_free;
    logic      hit;
    status_t   add_status;
    logic [TIME_W-1:0] sum_time;
    logic [AMOUNT_W-1:0] add_amt;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    // shared unit: one saturating add, one compare
    assign add_amt  = (state_reg == S_TICK_EVAL) ? rd_data_reg.interval : amount_reg;
    assign sum_time = sat_add(now_reg, add_amt);
    assign hit      = (fire_cnt_reg < FIRE_MAX) && (now_reg >= rd_data_reg.due);

    always_comb
    begin
        if (!cb_reg)
            add_status = ST_NO_CB;
        else if ((op_reg == OP_ADD_PER) && (amount_reg == '0))
            add_status = ST_ZERO_IV;
        else if (count_reg >= FULL_CNT)
            add_status = ST_FULL;
        else
            add_status = ST_OK;
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        now_next        = now_reg;
        amount_next     = amount_reg;
        tag_next        = tag_reg;
        cb_next         = cb_reg;
        count_next      = count_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        fire_cnt_next   = fire_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_tag_next   = pend_tag_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_kind_next   = out_kind_reg;
        out_status_next = out_status_reg;
        out_tag_next    = out_tag_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[AW-1:0];
        mem_wdata       = rd_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next     = op_t'(s_tuser);
                    now_next    = s_tdata[47:0];
                    amount_next = s_tdata[79:48];
                    tag_next    = s_tdata[95:80];
                    cb_next     = s_tdata[96];
                    state_next  = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (op_reg == OP_TICK)
                begin
                    rd_ptr_next     = '0;
                    wr_ptr_next     = '0;
                    fire_cnt_next   = '0;
                    pend_valid_next = 1'b0;
                    state_next      = S_TICK_RD;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_ACK;
                    out_tag_next    = '0;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                    if (op_reg == OP_CLEAR)
                    begin
                        out_status_next = ST_OK;
                        count_next      = '0;
                    end
                    else
                    begin
                        out_status_next = add_status;
                        if (add_status == ST_OK)
                        begin
                            mem_we             = 1'b1;
                            mem_waddr          = count_reg[AW-1:0];
                            mem_wdata.periodic = (op_reg == OP_ADD_PER);
                            mem_wdata.due      = sum_time;
                            mem_wdata.interval = (op_reg == OP_ADD_PER) ? amount_reg : '0;
                            mem_wdata.tag      = tag_reg;
                            count_next         = count_reg + 1'b1;
                        end
                    end
                end
            end

            S_TICK_RD:
            begin
                if (rd_ptr_reg == count_reg)
                    state_next = S_TICK_END;
                else
                    state_next = S_TICK_EVAL;
            end

            S_TICK_EVAL:
            begin
                // hold while an earlier fired word cannot be pushed out
                if (!(hit && pend_valid_reg && !out_free))
                begin
                    if (hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_kind_next   = KIND_FIRED;
                            out_status_next = ST_OK;
                            out_tag_next    = pend_tag_reg;
                            out_last_next   = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_tag_next   = rd_data_reg.tag;
                        fire_cnt_next   = fire_cnt_reg + 1'b1;
                    end
                    // keep unfired slots and fired periodic ones, packed down
                    if (!hit || rd_data_reg.periodic)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = wr_ptr_reg[AW-1:0];
                        if (hit)
                            mem_wdata.due = sum_time;
                        wr_ptr_next = wr_ptr_reg + 1'b1;
                    end
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                    state_next  = S_TICK_RD;
                end
            end

            S_TICK_END:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_last_next   = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_kind_next = KIND_FIRED;
                        out_tag_next  = pend_tag_reg;
                    end
                    else
                    begin
                        out_kind_next = KIND_NOTHING;
                        out_tag_next  = '0;
                    end
                    pend_valid_next = 1'b0;
                    count_next      = wr_ptr_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            fire_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            rd_ptr_reg     <= rd_ptr_next;
            wr_ptr_reg     <= wr_ptr_next;
            fire_cnt_reg   <= fire_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        now_reg        <= now_next;
        amount_reg     <= amount_next;
        tag_reg        <= tag_next;
        cb_reg         <= cb_next;
        pend_tag_reg   <= pend_tag_next;
        out_kind_reg   <= out_kind_next;
        out_status_reg <= out_status_next;
        out_tag_reg    <= out_tag_next;
        out_last_reg   <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[rd_ptr_reg[AW-1:0]];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {6'd0, out_tag_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("slot count above table size");

    a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
        wr_ptr_reg <= rd_ptr_reg)
        else $error("compaction write pointer ahead of read pointer");

    a_fire_limit: assert property (@(posedge clk) disable iff (!rst_n)
        fire_cnt_reg <= FIRE_MAX)
        else $error("fired word count above limit");

    a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_ACK || m_tuser == KIND_NOTHING)) |-> m_tlast)
        else $error("acknowledge or nothing-due word not marked last");

    a_pend_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("fired word left pending after tick");

endmodule
